// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

// File: sv/hbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

	localparam int SIZE_BITS = 32;
	localparam int LEN_BITS = 32;
	localparam int CFG_INDEX_W = 2;

	localparam logic [1:0] ST_WAIT = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_CHUNKED_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONTENT_LENGTH = 2'd1;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] ch);
		hex_digit_t r;
		logic [7:0] d;
		r.ok = 1'b1;
		d = 8'h00;
		if (ch inside {[8'h30:8'h39]}) begin
			d = ch - 8'h30;
		end else if (ch inside {[8'h41:8'h46]}) begin
			d = ch - 8'h37;
		end else if (ch inside {[8'h61:8'h66]}) begin
			d = ch - 8'h57;
		end else begin
			r.ok = 1'b0;
		end
		r.val = d[3:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/http_body_dechunker.sv
// HTTP body dechunker.
// Input channel: in_valid/in_ready carry one raw body byte per item on body_byte.
// Output channel: out_valid/out_ready carry one result item per input item:
// data_valid, data_out, chunk_last and status (0 waiting, 1 complete, 2 error).
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// sets chunked_mode, index 1 sets content_length and reloads the byte countdown.
// Other indexes are ignored. cfg_ready is always high; write only while idle.
// The result of an accepted byte is registered and shown on the output from the
// next cycle. Throughput is one byte per cycle while out_ready is high, set by
// the single result register; the decode step is one hex shift-add or decrement.
// When the receiver stalls, the result register holds and in_ready follows
// out_ready, so a new byte is taken in the same cycle the held result leaves.
// Reset clears all state: size-line parsing, length mode, countdown zero
// (unknown length) and status waiting. Done and error stay until reset.
`timescale 1ns / 1ps
`default_nettype none

module http_body_dechunker import hbd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             body_byte,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [LEN_BITS-1:0]    cfg_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        data_valid,
	output logic [7:0]                  data_out,
	output logic                        chunk_last,
	output logic [1:0]                  status
);

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_SIZE_CR,
		PH_EXT,
		PH_EXT_CR,
		PH_DATA,
		PH_SKIP1,
		PH_SKIP2
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [SIZE_BITS-1:0]   size_accum_q, size_accum_n;
	logic                   digit_seen_q, digit_seen_n;
	logic [SIZE_BITS-1:0]   data_left_q, data_left_n;
	logic [LEN_BITS-1:0]    length_left_q, length_left_n;
	logic [1:0]             final_status_q, final_status_n;
	logic                   chunked_mode_q;
	logic                   out_valid_q;
	logic                   res_valid, res_last;
	logic                   accept;
	hex_digit_t             hex;

	assign in_ready = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign hex = hex_value(body_byte);

	always_comb begin
		phase_n = phase_q;
		size_accum_n = size_accum_q;
		digit_seen_n = digit_seen_q;
		data_left_n = data_left_q;
		length_left_n = length_left_q;
		final_status_n = final_status_q;
		res_valid = 1'b0;
		res_last = 1'b0;
		if (final_status_q != ST_WAIT) begin
			res_valid = 1'b0;
		end else if (!chunked_mode_q) begin
			res_valid = 1'b1;
			if (length_left_q != '0) begin
				length_left_n = length_left_q - 1'b1;
				if (length_left_q == LEN_BITS'(1)) begin
					final_status_n = ST_DONE;
				end
			end
		end else begin
			case (phase_q)
				PH_SIZE: begin
					if (hex.ok) begin
						if (size_accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							final_status_n = ST_ERROR;
						end else begin
							size_accum_n = {size_accum_q[SIZE_BITS-5:0], hex.val};
							digit_seen_n = 1'b1;
						end
					end else if (body_byte == CH_SEMI) begin
						phase_n = PH_EXT;
					end else if (body_byte == CH_CR) begin
						phase_n = PH_SIZE_CR;
					end else begin
						final_status_n = ST_ERROR;
					end
				end
				PH_SIZE_CR, PH_EXT_CR: begin
					if (body_byte == CH_LF) begin
						if (!digit_seen_q) begin
							final_status_n = ST_ERROR;
						end else if (size_accum_q == '0) begin
							final_status_n = ST_DONE;
						end else begin
							data_left_n = size_accum_q;
							phase_n = PH_DATA;
						end
					end else if (phase_q == PH_SIZE_CR) begin
						final_status_n = ST_ERROR;
					end else if (body_byte != CH_CR) begin
						phase_n = PH_EXT;
					end
				end
				PH_EXT: begin
					if (body_byte == CH_CR) begin
						phase_n = PH_EXT_CR;
					end
				end
				PH_DATA: begin
					res_valid = 1'b1;
					if (data_left_q[SIZE_BITS-1:1] == '0) begin
						res_last = 1'b1;
						data_left_n = '0;
						phase_n = PH_SKIP1;
					end else begin
						data_left_n = data_left_q - 1'b1;
					end
				end
				PH_SKIP1: begin
					phase_n = PH_SKIP2;
				end
				default: begin
					phase_n = PH_SIZE;
					size_accum_n = '0;
					digit_seen_n = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			size_accum_q <= '0;
			digit_seen_q <= 1'b0;
			data_left_q <= '0;
			length_left_q <= '0;
			final_status_q <= ST_WAIT;
			chunked_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
			data_valid <= 1'b0;
			data_out <= 8'h00;
			chunk_last <= 1'b0;
			status <= ST_WAIT;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				size_accum_q <= size_accum_n;
				digit_seen_q <= digit_seen_n;
				data_left_q <= data_left_n;
				final_status_q <= final_status_n;
				out_valid_q <= 1'b1;
				data_valid <= res_valid;
				data_out <= res_valid ? body_byte : 8'h00;
				chunk_last <= res_last;
				status <= final_status_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_CONTENT_LENGTH) begin
				length_left_q <= cfg_data;
			end else if (accept) begin
				length_left_q <= length_left_n;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_CHUNKED_MODE) begin
				chunked_mode_q <= cfg_data[0];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/hbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hbd_checker import hbd_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   data_valid,
	input wire logic [7:0]             data_out,
	input wire logic                   chunk_last,
	input wire logic [1:0]             status
);

	logic       ended_q;
	logic [1:0] end_status_q;

	// Remember the first final outcome handed to the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
			end_status_q <= ST_WAIT;
		end else if (out_valid && out_ready && !ended_q && status != ST_WAIT) begin
			ended_q <= 1'b1;
			end_status_q <= status;
		end
	end

	`ASSERT_IMP(a_idle_payload_zero, clk, arst_n, out_valid && !data_valid,
		data_out == 8'h00 && !chunk_last)
	`ASSERT_IMP(a_status_code, clk, arst_n, out_valid, status != 2'd3)
	`ASSERT_IMP(a_sticky_end, clk, arst_n, out_valid && ended_q,
		status == end_status_q && !data_valid)
	`ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(data_out) && $stable(status) && $stable(data_valid))

endmodule

bind http_body_dechunker hbd_checker u_hbd_checker (.*);

`default_nettype wire
